@@ hdl/int_literal_char_parser_unit_macros.svh @@
// Assertion macros shared by the literal parser RTL.
`ifndef INT_LITERAL_CHAR_PARSER_UNIT_MACROS_SVH
`define INT_LITERAL_CHAR_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ILCP_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("ilcp assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define ILCP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("ilcp assertion failed: next-cycle check");

`endif

@@ hdl/ilcp_pkg.sv @@
// Package with codes, types and character decode for the literal parser.
package ilcp_pkg;

    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 3;
    localparam int DIGIT_W  = 4;
    localparam int WIDE_W   = VALUE_W + 4;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [VALUE_W-1:0]  acc_t;
    typedef logic [CHAR_W-1:0]   char_t;

    localparam mode_t MODE_START = 3'd0;
    localparam mode_t MODE_DEC   = 3'd1;
    localparam mode_t MODE_ZERO  = 3'd2;
    localparam mode_t MODE_OCT   = 3'd3;
    localparam mode_t MODE_HEX   = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_OCTAL = 2'd2;
    localparam status_t ST_DIGIT = 2'd3;

    localparam logic [WIDE_W-1:0] LIMIT = 36'h0_8000_0000;

    typedef struct packed {
        logic                is_dec;
        logic                is_oct;
        logic                is_hex;
        logic                is_zero;
        logic                is_x;
        logic [DIGIT_W-1:0]  digit;
    } char_class_t;

    function automatic char_class_t classify(input char_t c);
        char_class_t r;
        logic lower;
        logic upper;
        lower     = (c >= 8'h61) && (c <= 8'h66);
        upper     = (c >= 8'h41) && (c <= 8'h46);
        r.is_dec  = (c >= 8'h30) && (c <= 8'h39);
        r.is_oct  = (c >= 8'h30) && (c <= 8'h37);
        r.is_hex  = r.is_dec || lower || upper;
        r.is_zero = (c == 8'h30);
        r.is_x    = (c == 8'h78) || (c == 8'h58);
        if (r.is_dec) begin
            r.digit = c[DIGIT_W-1:0];
        end else begin
            r.digit = DIGIT_W'(c[2:0] + 3'd1) + DIGIT_W'(8);
        end
        return r;
    endfunction

endpackage

@@ hdl/int_literal_char_parser_unit.sv @@
// Streaming C integer literal parser: one character per transfer, one result per literal.
//
// Usage: send the characters of one literal on the s_ channel, one per transfer,
// with s_tlast high on the final character. A leading 0x/0X selects hex, a
// leading 0 octal, anything else decimal. After the final character one
// result appears on the m_ channel: m_tdata carries the 32-bit signed value
// (2^31 reads as the minimum value, 0 on error) and m_tuser the status
// (0 ok, 1 out of range, 2 bad octal digit, 3 invalid digit).
// Timing: a final character passes from the input register to the output register once
// the output is free. Throughput: one character per cycle unless a final one waits;
// the accumulator shift-add between the input and state registers sets that figure.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to its start state. When the receiver stalls, the result holds in
// the output register; characters not ending a literal still advance, and a
// final character waits in the input register until the output frees up.
module int_literal_char_parser_unit
    import ilcp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] char_code
    input  logic         s_tlast,   // last
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // [31:0] value
    output logic [1:0]   m_tuser    // [1:0] status
);

`include "int_literal_char_parser_unit_macros.svh"

    logic        s1_valid_reg;
    char_t       s1_char_reg;
    logic        s1_last_reg;

    mode_t       mode_reg,  mode_next;
    acc_t        acc_reg,   acc_next;
    status_t     err_reg,   err_next;

    logic        out_valid_reg;
    acc_t        out_value_reg, out_value_next;
    status_t     out_status_reg, out_status_next;

    logic        out_free;
    logic        step;
    logic        out_load;
    char_class_t cls;
    logic [WIDE_W-1:0] acc_wide;
    logic [WIDE_W-1:0] sum;
    logic        add_en;
    mode_t       mode_upd;
    status_t     err_upd;
    acc_t        acc_upd;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = s1_valid_reg && (!s1_last_reg || out_free);
    assign out_load = step && s1_last_reg;
    assign s_tready = !s1_valid_reg || step;

    assign cls      = classify(s1_char_reg);
    assign acc_wide = WIDE_W'(acc_reg);

    always_comb begin
        mode_upd = mode_reg;
        err_upd  = err_reg;
        add_en   = 1'b0;
        sum      = acc_wide;
        if (err_reg == ST_OK) begin
            unique case (mode_reg)
                MODE_START: begin
                    if (cls.is_zero) begin
                        mode_upd = MODE_ZERO;
                    end else begin
                        mode_upd = MODE_DEC;
                        add_en   = cls.is_dec;
                        sum      = (acc_wide << 3) + (acc_wide << 1) + WIDE_W'(cls.digit);
                        if (!cls.is_dec) err_upd = ST_DIGIT;
                    end
                end
                MODE_ZERO: begin
                    if (cls.is_x) begin
                        mode_upd = MODE_HEX;
                    end else begin
                        mode_upd = MODE_OCT;
                        add_en   = cls.is_oct;
                        sum      = (acc_wide << 3) + WIDE_W'(cls.digit);
                        if (!cls.is_oct) err_upd = ST_OCTAL;
                    end
                end
                MODE_OCT: begin
                    add_en = cls.is_oct;
                    sum    = (acc_wide << 3) + WIDE_W'(cls.digit);
                    if (!cls.is_oct) err_upd = ST_OCTAL;
                end
                MODE_HEX: begin
                    add_en = cls.is_hex;
                    sum    = (acc_wide << 4) + WIDE_W'(cls.digit);
                    if (!cls.is_hex) err_upd = ST_DIGIT;
                end
                default: begin
                    add_en = cls.is_dec;
                    sum    = (acc_wide << 3) + (acc_wide << 1) + WIDE_W'(cls.digit);
                    if (!cls.is_dec) err_upd = ST_DIGIT;
                end
            endcase
        end
        acc_upd = acc_reg;
        if (add_en) begin
            if (sum > LIMIT) begin
                err_upd = ST_RANGE;
            end else begin
                acc_upd = sum[VALUE_W-1:0];
            end
        end
    end

    always_comb begin
        mode_next       = mode_reg;
        acc_next        = acc_reg;
        err_next        = err_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        if (out_load) begin
            mode_next       = MODE_START;
            acc_next        = '0;
            err_next        = ST_OK;
            out_value_next  = (err_upd == ST_OK) ? acc_upd : '0;
            out_status_next = err_upd;
        end else if (step) begin
            mode_next = mode_upd;
            acc_next  = acc_upd;
            err_next  = err_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_START;
            acc_reg       <= '0;
            err_reg       <= ST_OK;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            s1_char_reg <= s_tdata;
            s1_last_reg <= s_tlast;
        end
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;

    `ILCP_ASSERT_NOW(a_err_zero_value, aclk, aresetn, out_valid_reg && (out_status_reg != ST_OK), out_value_reg == '0)
    `ILCP_ASSERT_NOW(a_acc_in_range, aclk, aresetn, 1'b1, acc_reg <= LIMIT[VALUE_W-1:0])
    `ILCP_ASSERT_NEXT(a_restart_after_result, aclk, aresetn, out_load, (mode_reg == MODE_START) && (err_reg == ST_OK) && (acc_reg == '0))
    `ILCP_ASSERT_NEXT(a_error_sticky, aclk, aresetn, (err_reg != ST_OK) && !out_load, err_reg == $past(err_reg))

endmodule

@@ sim/tb_int_literal_char_parser_unit.sv @@
// Self-checking testbench for the streaming C integer literal parser.
module tb_int_literal_char_parser_unit;
    import ilcp_pkg::*;

    localparam int          CYCLE_LIMIT = 300000;
    localparam logic [63:0] RANGE_CAP   = 64'h0000_0000_8000_0000;

    typedef char_t char_seq_t[$];

    typedef struct packed {
        acc_t    value;
        status_t status;
    } parse_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] char_code
    logic        s_tlast  = 1'b0;    // last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // [31:0] value
    logic [1:0]  m_tuser;            // [1:0] status

    mode_t   lit_mode = MODE_START;
    acc_t    lit_acc  = '0;
    status_t lit_err  = ST_OK;

    parse_result_t parsed_q[$];

    int idle_pct       = 0;
    int stall_pct      = 0;
    int stall_len      = 0;
    int stall_req      = 0;
    int stall_seen     = 0;
    int stall_left     = 0;
    int cycle_count    = 0;
    int chars_sent     = 0;
    int literals_sent  = 0;
    int results_seen   = 0;
    int mismatch_count = 0;

    int_literal_char_parser_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Hold off the receiver for a requested stretch, else stall at random.
    always @(posedge aclk) begin
        if (stall_req != stall_seen) begin
            stall_seen <= stall_req;
            stall_left <= stall_len;
            m_tready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(1, 100) > stall_pct);
        end
    end

    always @(negedge aclk) begin
        parse_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen = results_seen + 1;
            if (parsed_q.size() == 0) begin
                if (mismatch_count < 10)
                    $display("Unexpected result: value %h status %0d", m_tdata, m_tuser);
                mismatch_count = mismatch_count + 1;
            end else begin
                exp_r = parsed_q.pop_front();
                if (m_tdata !== exp_r.value || m_tuser !== exp_r.status) begin
                    if (mismatch_count < 10)
                        $display("Result %0d: expected value %h status %0d, got value %h status %0d",
                                 results_seen, exp_r.value, exp_r.status, m_tdata, m_tuser);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    function automatic void parse_char(input char_t c, input logic fin);
        logic [4:0]    radix;
        logic [4:0]    dig;
        logic [63:0]   nxt;
        parse_result_t r;
        radix = '0;
        if (lit_err == ST_OK) begin
            case (lit_mode)
                MODE_START: begin
                    if (c == "0") begin
                        lit_mode = MODE_ZERO;
                    end else begin
                        lit_mode = MODE_DEC;
                        radix    = 5'd10;
                    end
                end
                MODE_ZERO: begin
                    if (c == "x" || c == "X") begin
                        lit_mode = MODE_HEX;
                    end else begin
                        lit_mode = MODE_OCT;
                        radix    = 5'd8;
                    end
                end
                MODE_OCT: radix = 5'd8;
                MODE_HEX: radix = 5'd16;
                default:  radix = 5'd10;
            endcase
            if (radix != 0) begin
                if (c >= "0" && c <= "9")
                    dig = 5'(c - "0");
                else if (c >= "a" && c <= "f")
                    dig = 5'(c - "a" + 10);
                else if (c >= "A" && c <= "F")
                    dig = 5'(c - "A" + 10);
                else
                    dig = 5'd16;
                if (dig >= radix) begin
                    lit_err = (radix == 5'd8) ? ST_OCTAL : ST_DIGIT;
                end else begin
                    nxt = 64'(lit_acc) * 64'(radix) + 64'(dig);
                    if (nxt > RANGE_CAP)
                        lit_err = ST_RANGE;
                    else
                        lit_acc = nxt[31:0];
                end
            end
        end
        if (fin) begin
            r.value  = (lit_err == ST_OK) ? lit_acc : '0;
            r.status = lit_err;
            parsed_q.push_back(r);
            lit_mode = MODE_START;
            lit_acc  = '0;
            lit_err  = ST_OK;
        end
    endfunction

    function automatic char_seq_t text_chars(input string s);
        char_seq_t seq;
        for (int i = 0; i < s.len(); i++)
            seq.push_back(char_t'(s.getc(i)));
        return seq;
    endfunction

    task automatic send_char(input char_t c, input logic fin);
        logic took;
        while (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        parse_char(c, fin);
        chars_sent = chars_sent + 1;
    endtask

    task automatic send_literal(input char_seq_t seq);
        for (int i = 0; i < seq.size(); i++)
            send_char(seq[i], i == seq.size() - 1);
        literals_sent = literals_sent + 1;
    endtask

    task automatic send_random_literal();
        string       s;
        char_seq_t   seq;
        logic [63:0] v;
        int          fmt;
        int          shape;
        int          n;
        fmt   = $urandom_range(0, 2);
        shape = $urandom_range(0, 9);
        if (shape == 0)
            v = RANGE_CAP + 64'($urandom_range(0, 6)) - 64'd3;
        else
            v = {$urandom, $urandom} >> $urandom_range(20, 63);
        case (fmt)
            0: s = $sformatf("%0d", v);
            1: begin
                s = $sformatf("%0h", v);
                if ($urandom_range(0, 3) == 0)
                    s = {"0", s};
                if ($urandom_range(0, 15) == 0)
                    s = "";
                for (int i = 0; i < s.len(); i++)
                    if (s.getc(i) >= "a" && $urandom_range(0, 1))
                        s.putc(i, s.getc(i) - 8'h20);
                if ($urandom_range(0, 1))
                    s = {"0x", s};
                else
                    s = {"0X", s};
            end
            default: s = $sformatf("0%0o", v);
        endcase
        seq = text_chars(s);
        if (shape == 1) begin
            seq[$urandom_range(0, seq.size() - 1)] = char_t'($urandom_range(0, 255));
        end else if (shape == 2) begin
            seq.delete();
            n = $urandom_range(1, 4);
            repeat (n) seq.push_back(char_t'($urandom_range(0, 255)));
        end
        send_literal(seq);
    endtask

    task automatic test_bare_prefixes();
        send_literal(text_chars("0"));
        send_literal(text_chars("0X"));
        send_literal(text_chars("7"));
    endtask

    task automatic test_range_limit();
        send_literal(text_chars("0x80000000"));
    endtask

    task automatic test_digit_errors();
        send_literal(text_chars("09"));
        send_literal(text_chars("0xg7"));
        send_literal('{8'hFF});
        send_literal('{"1", 8'h00});
    endtask

    task automatic test_random_traffic(input int sender_idle, input int recv_stall,
                                       input int n_chars);
        int start;
        idle_pct  = sender_idle;
        stall_pct = recv_stall;
        start     = chars_sent;
        while (chars_sent - start < n_chars)
            send_random_literal();
    endtask

    task automatic test_output_stall();
        idle_pct  = 0;
        stall_pct = 0;
        stall_len = 400;
        stall_req = stall_req + 1;
        for (int k = 0; k < 24; k++)
            send_literal(text_chars($sformatf("%0d", k % 10)));
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_bare_prefixes();
        test_range_limit();
        test_digit_errors();
        test_random_traffic(0, 0, 175);
        test_random_traffic(64, 0, 175);
        test_output_stall();
        test_random_traffic(0, 64, 175);
        test_random_traffic(6, 6, 175);

        s_tvalid <= 1'b0;
        while (parsed_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d characters in %0d literals across four idle/stall mixes",
                 chars_sent, literals_sent);
        $display("Checked %0d results, %0d mismatches", results_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/ilcp_pkg.sv
hdl/int_literal_char_parser_unit.sv
sim/tb_int_literal_char_parser_unit.sv
